// ===== hdl/sbg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared types, widths, constants and the sine table of the beep generator.
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int unsigned TableDepth  = 64;
  localparam int unsigned PhaseW      = 6;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned LeftW       = 22;
  localparam int unsigned VolW        = 7;
  localparam int unsigned FreqW       = 15;
  localparam int unsigned DurW        = 16;
  localparam int unsigned BeepVolW    = 8;
  localparam int unsigned RateW       = 16;
  localparam int unsigned DivW        = 32;
  localparam int unsigned DivisorW    = 16;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CfgSampleRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseVolume = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStereoMode = 2'd2;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam logic [RateW-1:0]    RateReset    = 16'd8000;
  localparam logic [VolW-1:0]     BaseVolReset = 7'd80;
  localparam logic [BeepVolW-1:0] MaxPercent   = 8'd100;
  localparam logic [DivisorW-1:0] MsPerSecond  = 16'd1000;
  localparam logic [DivW-1:0]     LeftMax      = 32'd4194303;

  // reciprocal of 100 for magnitudes below 2^22
  localparam int unsigned  MagW      = 22;
  localparam int unsigned  RecipW    = 23;
  localparam int unsigned  RecipSh   = 29;
  localparam logic [RecipW-1:0] Recip100 = 23'd5368710;

  // reciprocal of 125 for the length; the product first drops three bits
  localparam int unsigned  LenDropSh  = 3;
  localparam int unsigned  LenMagW    = DivW - LenDropSh;
  localparam int unsigned  Recip125W  = 30;
  localparam int unsigned  Recip125Sh = 36;
  localparam logic [Recip125W-1:0] Recip125 = 30'd549755814;

  localparam logic signed [SampleW-1:0] SatHi = 16'sd32767;
  localparam logic signed [SampleW-1:0] SatLo = -16'sd32768;

  localparam logic signed [SampleW-1:0] SINE_ROM [TableDepth] = '{
    16'sd0, 16'sd3212, 16'sd6393, 16'sd9512, 16'sd12540, 16'sd15446, 16'sd18205, 16'sd20787,
    16'sd23170, 16'sd25330, 16'sd27246, 16'sd28899, 16'sd30273, 16'sd31357, 16'sd32138,
    16'sd32610,
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30273, 16'sd28899, 16'sd27246,
    16'sd25330,
    16'sd23170, 16'sd20787, 16'sd18205, 16'sd15446, 16'sd12540, 16'sd9512, 16'sd6393,
    16'sd3212,
    16'sd0, -16'sd3212, -16'sd6393, -16'sd9512, -16'sd12540, -16'sd15446, -16'sd18205,
    -16'sd20787,
    -16'sd23170, -16'sd25330, -16'sd27246, -16'sd28899, -16'sd30273, -16'sd31357,
    -16'sd32138, -16'sd32610,
    -16'sd32767, -16'sd32610, -16'sd32138, -16'sd31357, -16'sd30273, -16'sd28899,
    -16'sd27246, -16'sd25330,
    -16'sd23170, -16'sd20787, -16'sd18205, -16'sd15446, -16'sd12540, -16'sd9512,
    -16'sd6393, -16'sd3212
  };

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/sbg_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbg_divider
// Restoring divider, one quotient bit per cycle, used by the start sequence.
// ----------------------------------------------------------------------------
module sbg_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbg_pkg::div_req_t req_i,
  output sbg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(sbg_pkg::DivW);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [sbg_pkg::DivW-1:0]      quo_q, quo_d;
  logic [sbg_pkg::DivisorW-1:0]  rem_q, rem_d;
  logic [sbg_pkg::DivisorW-1:0]  dvs_q, dvs_d;
  logic [sbg_pkg::DivisorW:0]    trial;
  logic [sbg_pkg::DivisorW:0]    diff;

  assign trial = {rem_q, quo_q[sbg_pkg::DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(sbg_pkg::DivW - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[sbg_pkg::DivisorW-1:0];
        quo_d = {quo_q[sbg_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[sbg_pkg::DivisorW-1:0];
        quo_d = {quo_q[sbg_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/sbg_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbg_scaler
// Sine lookup, volume multiply, divide by 100 and saturation over three stages.
// ----------------------------------------------------------------------------
module sbg_scaler (
  input  logic                               clk_i,
  input  logic [sbg_pkg::PhaseW-1:0]         phase_i,
  input  logic [sbg_pkg::VolW-1:0]           vol_i,
  output logic signed [sbg_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned ProdW = sbg_pkg::SampleW + sbg_pkg::VolW + 1;
  localparam int unsigned MqW   = sbg_pkg::MagW + sbg_pkg::RecipW;

  logic signed [sbg_pkg::SampleW-1:0] raw_q;
  logic [sbg_pkg::VolW-1:0]           vol_q;
  logic signed [ProdW-1:0]            prod;
  logic signed [ProdW-1:0]            prod_abs;
  logic [sbg_pkg::MagW-1:0]           mag_q;
  logic                               neg_q, neg2_q;
  logic [MqW-1:0]                     mq_q;
  logic [sbg_pkg::SampleW-1:0]        quo;

  assign prod     = ProdW'(raw_q) * ProdW'($signed({1'b0, vol_q}));
  assign prod_abs = prod[ProdW-1] ? -prod : prod;

  always_ff @(posedge clk_i) begin
    raw_q  <= sbg_pkg::SINE_ROM[phase_i];
    vol_q  <= vol_i;
    mag_q  <= prod_abs[sbg_pkg::MagW-1:0];
    neg_q  <= prod[ProdW-1];
    mq_q   <= MqW'(mag_q) * MqW'(sbg_pkg::Recip100);
    neg2_q <= neg_q;
  end

  assign quo = mq_q[sbg_pkg::RecipSh +: sbg_pkg::SampleW];

  always_comb begin
    if (!neg2_q) begin
      sample_o = (quo > sbg_pkg::SatHi) ? sbg_pkg::SatHi : $signed(quo);
    end else begin
      sample_o = (quo > sbg_pkg::SatHi) ? sbg_pkg::SatLo : -$signed(quo);
    end
  end

endmodule

// ===== hdl/sine_beep_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_beep_generator_core
// Sine beep synthesis from a 64-entry table with start and tick items.
// ----------------------------------------------------------------------------
//  channel   signals                 contents
//  s_axis    tvalid tready tdata     tdata: tone_freq, beep_len_ms, beep_volume
//            tuser                   tuser: op (0 start, 1 tick)
//  m_axis    tvalid tready tdata     tdata: left_sample, right_sample
//            tlast                   tlast: last_sample
//  cfg       we index wdata          0 out_rate, 1 base_volume, 2 stereo_mode
//
//  a tick item passes through accept, three scaler stages and output load
//  a start item runs accept with the rate by length multiply, then the length
//  by reciprocal multiply, then the divider, which only the start sequence uses
//  a start at zero rate skips the divider; an ignored start or idle tick ends at accept
//  a tick stalls at output load while the previous result waits for tready
//  reset returns all control state to its reset values; the sine table is constant
// ----------------------------------------------------------------------------
module sine_beep_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // tone_freq, beep_len_ms, beep_volume
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // left_sample, right_sample
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [sbg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbg_pkg::RateW-1:0]     cfg_wdata_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDivS = 3'd3;
  localparam logic [2:0] StTick = 3'd4;

  localparam int unsigned LenProdW = sbg_pkg::LenMagW + sbg_pkg::Recip125W;

  logic [2:0] state_q, state_d;

  logic [sbg_pkg::RateW-1:0]    rate_q;
  logic [sbg_pkg::VolW-1:0]     base_vol_q;
  logic                         stereo_q;

  logic [sbg_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [sbg_pkg::PhaseW-1:0]   step_q, step_d;
  logic [sbg_pkg::LeftW-1:0]    left_q, left_d;
  logic [sbg_pkg::VolW-1:0]     act_vol_q, act_vol_d;

  logic [sbg_pkg::DivW-1:0]     prod_q, prod_d;
  logic [sbg_pkg::FreqW-1:0]    freq_q, freq_d;
  logic [sbg_pkg::VolW-1:0]     pend_vol_q, pend_vol_d;
  logic [sbg_pkg::LeftW:0]      pend_left_q, pend_left_d;
  logic [LenProdW-1:0]          len_prod;

  logic [sbg_pkg::PhaseW-1:0]   tick_phase_q, tick_phase_d;
  logic [sbg_pkg::VolW-1:0]     tick_vol_q, tick_vol_d;
  logic                         tick_last_q, tick_last_d;
  logic [1:0]                   cnt_q, cnt_d;

  logic                         ov_q, ov_d;
  logic [sbg_pkg::SampleW-1:0]  ol_q, ol_d;
  logic [sbg_pkg::SampleW-1:0]  or_q, or_d;
  logic                         olast_q, olast_d;

  logic                         in_acc;
  logic                         op;
  logic [sbg_pkg::FreqW-1:0]    freq;
  logic [sbg_pkg::DurW-1:0]     dur;
  logic [sbg_pkg::BeepVolW-1:0] bvol;
  logic signed [sbg_pkg::SampleW-1:0] sample;
  logic                         out_free;

  sbg_pkg::div_req_t div_req;
  sbg_pkg::div_rsp_t div_rsp;

  assign op   = s_axis_tuser;
  assign freq = s_axis_tdata[14:0];
  assign dur  = s_axis_tdata[30:15];
  assign bvol = s_axis_tdata[38:31];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  // length divided by 1000 as a drop of three bits and a multiply by 1/125
  assign len_prod = LenProdW'(prod_q[sbg_pkg::DivW-1:sbg_pkg::LenDropSh])
                  * LenProdW'(sbg_pkg::Recip125);

  sbg_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  sbg_scaler u_scale (
    .clk_i   (clk_i),
    .phase_i (tick_phase_q),
    .vol_i   (tick_vol_q),
    .sample_o(sample)
  );

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    step_d       = step_q;
    left_d       = left_q;
    act_vol_d    = act_vol_q;
    prod_d       = prod_q;
    freq_d       = freq_q;
    pend_vol_d   = pend_vol_q;
    pend_left_d  = pend_left_q;
    tick_phase_d = tick_phase_q;
    tick_vol_d   = tick_vol_q;
    tick_last_d  = tick_last_q;
    cnt_d        = cnt_q;
    ov_d         = ov_q && !m_axis_tready;
    ol_d         = ol_q;
    or_d         = or_q;
    olast_d      = olast_q;
    div_req      = '0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (op == sbg_pkg::OpStart) begin
            if (freq != '0 && dur != '0) begin
              prod_d     = sbg_pkg::DivW'(rate_q) * sbg_pkg::DivW'(dur);
              freq_d     = freq;
              pend_vol_d = (bvol <= sbg_pkg::MaxPercent) ? bvol[sbg_pkg::VolW-1:0]
                                                         : base_vol_q;
              state_d    = StMul;
            end
          end else if (left_q != '0) begin
            tick_phase_d = phase_q;
            tick_vol_d   = act_vol_q;
            tick_last_d  = (left_q == sbg_pkg::LeftW'(1));
            left_d       = left_q - 1'b1;
            phase_d      = phase_q + step_q;
            cnt_d        = '0;
            state_d      = StTick;
          end
        end
      end
      StMul: begin
        pend_left_d = len_prod[sbg_pkg::Recip125Sh +: (sbg_pkg::LeftW + 1)];
        if (rate_q == '0) begin
          left_d    = '0;
          step_d    = sbg_pkg::PhaseW'(1);
          phase_d   = '0;
          act_vol_d = pend_vol_q;
          state_d   = StIdle;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sbg_pkg::DivW'({freq_q, {sbg_pkg::PhaseW{1'b0}}});
          div_req.divisor  = rate_q;
          state_d          = StDivS;
        end
      end
      StDivS: begin
        if (div_rsp.done) begin
          left_d    = pend_left_q[sbg_pkg::LeftW] ? sbg_pkg::LeftMax[sbg_pkg::LeftW-1:0]
                                                  : pend_left_q[sbg_pkg::LeftW-1:0];
          step_d    = (div_rsp.quotient == '0) ? sbg_pkg::PhaseW'(1)
                                               : div_rsp.quotient[sbg_pkg::PhaseW-1:0];
          phase_d   = '0;
          act_vol_d = pend_vol_q;
          state_d   = StIdle;
        end
      end
      StTick: begin
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 1'b1;
        end else if (out_free) begin
          ov_d    = 1'b1;
          ol_d    = sample;
          or_d    = stereo_q ? sample : '0;
          olast_d = tick_last_q;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rate_q     <= sbg_pkg::RateReset;
      base_vol_q <= sbg_pkg::BaseVolReset;
      stereo_q   <= 1'b1;
      phase_q    <= '0;
      step_q     <= sbg_pkg::PhaseW'(1);
      left_q     <= '0;
      act_vol_q  <= '0;
      cnt_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      left_q    <= left_d;
      act_vol_q <= act_vol_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sbg_pkg::CfgSampleRate: rate_q     <= cfg_wdata_i;
          sbg_pkg::CfgBaseVolume: base_vol_q <= cfg_wdata_i[sbg_pkg::VolW-1:0];
          sbg_pkg::CfgStereoMode: stereo_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    freq_q       <= freq_d;
    pend_vol_q   <= pend_vol_d;
    pend_left_q  <= pend_left_d;
    tick_phase_q <= tick_phase_d;
    tick_vol_q   <= tick_vol_d;
    tick_last_q  <= tick_last_d;
    ol_q         <= ol_d;
    or_q         <= or_d;
    olast_q      <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {or_q, ol_q};
  assign m_axis_tlast  = olast_q;

endmodule
